// ----- rtl/ace_pkg.sv -----
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types, widths and instruction codes of the accumulator controller
// execute core.
// ----------------------------------------------------------------------------
package ace_pkg;

   // Architectural widths.
   localparam int ACE_D_W     = 8;   // data and accumulator width
   localparam int ACE_D_ADR_W = 6;   // data memory address width
   localparam int ACE_PC_W    = 10;  // program counter width
   localparam int ACE_IRQ_W   = 2;   // number of interrupt vector slots
   localparam int ACE_MEM_DEPTH = 1 << ACE_D_ADR_W;

   // Word field widths.
   localparam int ACE_KIND_W  = 5;
   localparam int ACE_FETCH_W = 4;
   localparam int ACE_VEC_W   = (ACE_PC_W < ACE_D_W) ? ACE_PC_W : ACE_D_W;

   // Configuration port.
   localparam int ACE_CSR_IDX_W  = 1;
   localparam int ACE_CSR_DATA_W = 8;
   localparam logic [ACE_CSR_IDX_W-1:0] CSR_TIMER_VEC = 1'd0;
   localparam logic [ACE_CSR_IDX_W-1:0] CSR_EXT_VEC   = 1'd1;

   // Derived constants.
   localparam logic [ACE_D_W-1:0] ACE_D_MAX = ACE_D_W'((1 << ACE_D_W) - 1);
   localparam logic [ACE_D_ADR_W-1:0] ACE_CFG_SLOT =
      ACE_D_ADR_W'((1 << ACE_D_ADR_W) - ACE_IRQ_W - 1);
   localparam logic [ACE_PC_W-1:0] ACE_VEC_MASK = ACE_PC_W'((1 << ACE_VEC_W) - 1);

   // Instruction codes.
   localparam logic [ACE_KIND_W-1:0] K_LDI   = 5'd0;
   localparam logic [ACE_KIND_W-1:0] K_CMPI  = 5'd1;
   localparam logic [ACE_KIND_W-1:0] K_ADDI  = 5'd2;
   localparam logic [ACE_KIND_W-1:0] K_SUBI  = 5'd3;
   localparam logic [ACE_KIND_W-1:0] K_LD    = 5'd4;
   localparam logic [ACE_KIND_W-1:0] K_ST    = 5'd5;
   localparam logic [ACE_KIND_W-1:0] K_STL   = 5'd6;
   localparam logic [ACE_KIND_W-1:0] K_CST   = 5'd7;
   localparam logic [ACE_KIND_W-1:0] K_CSTL  = 5'd8;
   localparam logic [ACE_KIND_W-1:0] K_LIS   = 5'd9;
   localparam logic [ACE_KIND_W-1:0] K_LISL  = 5'd10;
   localparam logic [ACE_KIND_W-1:0] K_LDS   = 5'd11;
   localparam logic [ACE_KIND_W-1:0] K_LDSL  = 5'd12;
   localparam logic [ACE_KIND_W-1:0] K_DBNE  = 5'd13;
   localparam logic [ACE_KIND_W-1:0] K_BNE   = 5'd14;
   localparam logic [ACE_KIND_W-1:0] K_SLEEP = 5'd15;

   // One instruction word as it enters the core.
   typedef struct packed {
      logic [ACE_KIND_W-1:0]  kind;
      logic [ACE_D_W-1:0]     immediate;
      logic [ACE_D_ADR_W-1:0] mem_address;
      logic [ACE_FETCH_W-1:0] fetch_words;
      logic                   wake_timer;
      logic                   wake_external;
   } ace_item_type;

   // Architectural state held in flip-flops.
   typedef struct packed {
      logic [ACE_PC_W-1:0]    pc;
      logic [ACE_D_W-1:0]     acc;
      logic                   carry;
      logic                   zero;
      logic [ACE_D_ADR_W-1:0] mptr;
      logic                   cfg_seen;
   } ace_arch_type;

   // Result word.
   typedef struct packed {
      logic [ACE_PC_W-1:0]    next_pc;
      logic [ACE_D_W-1:0]     accumulator_out;
      logic                   carry_out;
      logic                   zero_out;
      logic                   store_valid;
      logic [ACE_D_ADR_W-1:0] store_addr;
      logic [ACE_D_W-1:0]     store_data;
      logic                   first_config_done;
      logic                   still_asleep;
   } ace_result_type;

   // True for the variants that reuse the stored memory pointer.
   function automatic logic ace_uses_mptr(input logic [ACE_KIND_W-1:0] kind);
      return (kind == K_STL) || (kind == K_CSTL) || (kind == K_LISL) ||
             (kind == K_LDSL);
   endfunction

endpackage

// ----- rtl/ace_channel_if.sv -----
// ----------------------------------------------------------------------------
// ace_channel_if
// Valid/ready channels of the execute core: instruction words in, result
// words out.
// ----------------------------------------------------------------------------
interface ace_req_if;
   logic                                valid;
   logic                                ready;
   logic [ace_pkg::ACE_KIND_W-1:0]      kind;
   logic [ace_pkg::ACE_D_W-1:0]         immediate;
   logic [ace_pkg::ACE_D_ADR_W-1:0]     mem_address;
   logic [ace_pkg::ACE_FETCH_W-1:0]     fetch_words;
   logic                                wake_timer;
   logic                                wake_external;

   modport source (output valid, kind, immediate, mem_address, fetch_words,
                   wake_timer, wake_external, input ready);
   modport sink   (input valid, kind, immediate, mem_address, fetch_words,
                   wake_timer, wake_external, output ready);
endinterface

interface ace_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ace_pkg::ACE_PC_W-1:0]        next_pc;
   logic [ace_pkg::ACE_D_W-1:0]         accumulator_out;
   logic                                carry_out;
   logic                                zero_out;
   logic                                store_valid;
   logic [ace_pkg::ACE_D_ADR_W-1:0]     store_addr;
   logic [ace_pkg::ACE_D_W-1:0]         store_data;
   logic                                first_config_done;
   logic                                still_asleep;

   modport source (output valid, next_pc, accumulator_out, carry_out, zero_out,
                   store_valid, store_addr, store_data, first_config_done,
                   still_asleep, input ready);
   modport sink   (input valid, next_pc, accumulator_out, carry_out, zero_out,
                   store_valid, store_addr, store_data, first_config_done,
                   still_asleep, output ready);
endinterface

// ----- rtl/ace_exec.sv -----
// ----------------------------------------------------------------------------
// ace_exec
// Combinational execute unit: applies one instruction to the architectural
// state and the data memory read word, giving the next state and the result.
// ----------------------------------------------------------------------------
module ace_exec (
   input  ace_pkg::ace_item_type            item,
   input  ace_pkg::ace_arch_type            arch,
   input  logic [ace_pkg::ACE_D_W-1:0]      mem_rdata,
   input  logic [ace_pkg::ACE_D_W-1:0]      timer_vec,
   input  logic [ace_pkg::ACE_D_W-1:0]      ext_vec,
   output ace_pkg::ace_arch_type            arch_next,
   output ace_pkg::ace_result_type          result
);
   import ace_pkg::*;

   logic [ACE_PC_W-1:0] pc_adv;
   logic [ACE_D_W:0]    acc_ext;
   logic [ACE_D_W:0]    imm_ext;
   logic [ACE_D_W:0]    rd_ext;
   logic [ACE_D_W:0]    res;
   logic                res_we;
   logic                store;
   logic                asleep;
   logic                zero_new;

   assign pc_adv  = arch.pc + ACE_PC_W'(item.fetch_words);
   assign acc_ext = {1'b0, arch.acc};
   assign imm_ext = {1'b0, item.immediate};
   assign rd_ext  = {1'b0, mem_rdata};

   // Operation decode and accumulator arithmetic.
   always_comb begin
      arch_next = arch;
      arch_next.pc = pc_adv;
      res    = '0;
      res_we = 1'b0;
      store  = 1'b0;
      asleep = 1'b0;
      unique case (item.kind)
         K_LDI: begin
            res = imm_ext;
            res_we = 1'b1;
         end
         K_CMPI: begin
            arch_next.zero = (arch.acc == item.immediate);
         end
         K_ADDI: begin
            res = acc_ext + imm_ext;
            res_we = 1'b1;
         end
         K_SUBI: begin
            res = acc_ext - imm_ext;
            res_we = 1'b1;
         end
         K_LD: begin
            arch_next.mptr = item.mem_address;
            res = rd_ext;
            res_we = 1'b1;
         end
         K_ST: begin
            arch_next.mptr = item.mem_address;
            store = 1'b1;
         end
         K_STL: begin
            store = 1'b1;
         end
         K_CST: begin
            arch_next.mptr = item.mem_address;
            res_we = 1'b1;
            store = 1'b1;
         end
         K_CSTL: begin
            res_we = 1'b1;
            store = 1'b1;
         end
         K_LIS: begin
            arch_next.mptr = item.mem_address;
            res = rd_ext + 1'b1;
            res_we = 1'b1;
            store = 1'b1;
         end
         K_LISL: begin
            res = rd_ext + 1'b1;
            res_we = 1'b1;
            store = 1'b1;
         end
         K_LDS: begin
            arch_next.mptr = item.mem_address;
            res = rd_ext - 1'b1;
            res_we = 1'b1;
            store = 1'b1;
         end
         K_LDSL: begin
            res = rd_ext - 1'b1;
            res_we = 1'b1;
            store = 1'b1;
         end
         K_DBNE: begin
            res = acc_ext - 1'b1;
            res_we = 1'b1;
         end
         K_BNE: begin
         end
         K_SLEEP: begin
            // The timer wake wins; with no wake pending the pc holds.
            if (item.wake_timer) begin
               arch_next.pc = (pc_adv & ~ACE_VEC_MASK) |
                              (ACE_PC_W'(timer_vec) & ACE_VEC_MASK);
            end else if (item.wake_external) begin
               arch_next.pc = (pc_adv & ~ACE_VEC_MASK) |
                              (ACE_PC_W'(ext_vec) & ACE_VEC_MASK);
            end else begin
               arch_next.pc = arch.pc;
               asleep = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (res_we) begin
         arch_next.acc   = res[ACE_D_W-1:0];
         arch_next.carry = res[ACE_D_W];
         arch_next.zero  = (res[ACE_D_W-1:0] == '0);
      end

      // Branches look at the zero flag after a possible decrement.
      zero_new = arch_next.zero;
      if (((item.kind == K_DBNE) || (item.kind == K_BNE)) && !zero_new) begin
         arch_next.pc = pc_adv + ACE_PC_W'(item.immediate);
      end

      if (store && (arch_next.mptr == ACE_CFG_SLOT)) begin
         arch_next.cfg_seen = 1'b1;
      end
   end

   // Result word.
   always_comb begin
      result.next_pc           = arch_next.pc;
      result.accumulator_out   = arch_next.acc;
      result.carry_out         = arch_next.carry;
      result.zero_out          = arch_next.zero;
      result.store_valid       = store;
      result.store_addr        = store ? arch_next.mptr : '0;
      result.store_data        = store ? arch_next.acc : '0;
      result.first_config_done = arch_next.cfg_seen;
      result.still_asleep      = asleep;
   end

endmodule

// ----- rtl/accumulator_controller_execute_core.sv -----
// ----------------------------------------------------------------------------
// accumulator_controller_execute_core
// Executes one fetched instruction of the accumulator controller per word,
// with the data memory held in a synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
// Path: the input buffer loads at the accepting edge; the memory read is
// registered with the word, then the execute writes the output register.
// A new word is buffered while one executes, but its memory read waits for
// the execute and write-back of the previous instruction.
// Reset: synchronous, active high; clears pc, accumulator, flags, pointer,
// the sticky configuration flag, wake vectors and all valid bits. The data
// memory is not cleared.
module accumulator_controller_execute_core (
   input  logic                                  clock,
   input  logic                                  reset,
   ace_req_if.sink                               req_ch,
   ace_rsp_if.source                             rsp_ch,
   input  logic                                  csr_we,
   input  logic [ace_pkg::ACE_CSR_IDX_W-1:0]     csr_index,
   input  logic [ace_pkg::ACE_CSR_DATA_W-1:0]    csr_wdata
);
   import ace_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic [ACE_D_W-1:0]     timer_vec_ff;
   logic [ACE_D_W-1:0]     ext_vec_ff;

   logic                   ib_valid_ff;
   ace_item_type           ib_item_ff;
   ace_item_type           req_item;

   logic                   st_ff;
   logic                   st_in;
   ace_item_type           ex_item_ff;

   ace_arch_type           arch_ff;
   ace_arch_type           arch_in;
   ace_result_type         result;

   logic [ACE_D_W-1:0]     dmem [ACE_MEM_DEPTH];
   logic [ACE_D_W-1:0]     rdata_ff;
   logic [ACE_D_ADR_W-1:0] rd_addr;

   logic                   rsp_valid_ff;
   ace_result_type         rsp_data_ff;

   logic                   req_fire;
   logic                   issue;
   logic                   ex_fire;

   // Handshake decode.
   assign issue    = ib_valid_ff && (st_ff == ST_IDLE);
   assign ex_fire  = (st_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !ib_valid_ff || issue;

   // Wake vector registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_vec_ff <= '0;
         ext_vec_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMER_VEC: timer_vec_ff <= csr_wdata;
            CSR_EXT_VEC:   ext_vec_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input buffer takes a new word while the previous one executes.
   always_comb begin
      req_item.kind          = req_ch.kind;
      req_item.immediate     = req_ch.immediate;
      req_item.mem_address   = req_ch.mem_address;
      req_item.fetch_words   = req_ch.fetch_words;
      req_item.wake_timer    = req_ch.wake_timer;
      req_item.wake_external = req_ch.wake_external;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ib_valid_ff <= 1'b0;
      end else if (req_fire) begin
         ib_valid_ff <= 1'b1;
      end else if (issue) begin
         ib_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ib_item_ff <= req_item;
      end
   end

   // Two-phase sequencer: read the memory, then execute and write back.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (issue) st_in = ST_EXEC;
         ST_EXEC: if (ex_fire) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         ex_item_ff <= ib_item_ff;
      end
   end

   // The pointer is final here, since the previous word has been written back.
   assign rd_addr = ace_uses_mptr(ib_item_ff.kind) ? arch_ff.mptr : ib_item_ff.mem_address;

   // Data memory: one read port, one write port.
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= dmem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire && result.store_valid) begin
         dmem[result.store_addr] <= result.store_data;
      end
   end

   // Execute unit.
   ace_exec u_exec (
      .item      (ex_item_ff),
      .arch      (arch_ff),
      .mem_rdata (rdata_ff),
      .timer_vec (timer_vec_ff),
      .ext_vec   (ext_vec_ff),
      .arch_next (arch_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff <= '0;
      end else if (ex_fire) begin
         arch_ff <= arch_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.next_pc           = rsp_data_ff.next_pc;
   assign rsp_ch.accumulator_out   = rsp_data_ff.accumulator_out;
   assign rsp_ch.carry_out         = rsp_data_ff.carry_out;
   assign rsp_ch.zero_out          = rsp_data_ff.zero_out;
   assign rsp_ch.store_valid       = rsp_data_ff.store_valid;
   assign rsp_ch.store_addr        = rsp_data_ff.store_addr;
   assign rsp_ch.store_data        = rsp_data_ff.store_data;
   assign rsp_ch.first_config_done = rsp_data_ff.first_config_done;
   assign rsp_ch.still_asleep      = rsp_data_ff.still_asleep;

   // The configuration flag never clears once set.
   a_cfg_sticky: assert property (@(posedge clock) disable iff (reset)
      arch_ff.cfg_seen |=> arch_ff.cfg_seen)
      else $error("configuration flag cleared");

   // A buffered word always moves on to the execute phase.
   a_issue_exec: assert property (@(posedge clock) disable iff (reset)
      issue |=> (st_ff == ST_EXEC))
      else $error("issued word did not reach execute");

   // Every executed word shows up as a valid result.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      ex_fire |=> rsp_valid_ff)
      else $error("executed word produced no result");

   // Architectural state only changes when a word executes.
   a_arch_hold: assert property (@(posedge clock) disable iff (reset)
      !ex_fire |=> $stable(arch_ff))
      else $error("state changed without execution");

endmodule
